// ===== rtl/core/erm_pkg.sv =====
// ----------------------------------------------------------------------------
// erm_pkg: shared constants and types for the euler rotation matrix
// working word of 30 fraction bits, cordic angle table, lane payload types
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int WFRAC = 30;
    localparam int WW = 34;   // working word: signed, room for +-2*pi at 2^-30
    localparam int PW = 2 * WW;

    localparam int DEF_ANGLE_FRAC_BITS = 13;
    localparam int DEF_COEF_FRAC_BITS  = 14;
    localparam int DEF_CORDIC_STAGES   = 16;

    localparam logic signed [WW-1:0] ONE_W      = 34'sd1073741824;
    localparam logic signed [WW-1:0] PI_W       = 34'sd3373259426;
    localparam logic signed [WW-1:0] HALF_PI_W  = 34'sd1686629713;
    localparam logic signed [WW-1:0] TWO_PI_W   = 34'sd6746518852;
    localparam logic signed [WW-1:0] GAIN_INV_W = 34'sd652032874;

    typedef logic signed [WW-1:0] word_t;

    typedef struct packed {
        word_t s;
        word_t c;
    } sincos_t;

    function automatic word_t atan_step(input int i);
        case (i)
            0: atan_step = 34'sd843314857;
            1: atan_step = 34'sd497837829;
            2: atan_step = 34'sd263043837;
            3: atan_step = 34'sd133525159;
            4: atan_step = 34'sd67021687;
            5: atan_step = 34'sd33543516;
            6: atan_step = 34'sd16775851;
            7: atan_step = 34'sd8388437;
            8: atan_step = 34'sd4194283;
            9: atan_step = 34'sd2097149;
            default: begin
                if (i <= 30) atan_step = word_t'(34'sd1 <<< (30 - i));
                else atan_step = '0;
            end
        endcase
    endfunction

    function automatic word_t sat_w(input word_t v);
        if (v > ONE_W) sat_w = ONE_W;
        else if (v < -ONE_W) sat_w = -ONE_W;
        else sat_w = v;
    endfunction

    // rounded product of two values at 2^-30, both within +-1
    function automatic word_t mulw(input word_t a, input word_t b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b) + (PW'(1) <<< (WFRAC - 1));
        mulw = word_t'(p >>> WFRAC);
    endfunction

endpackage

// ===== rtl/core/erm_cordic.sv =====
// ----------------------------------------------------------------------------
// erm_cordic: one sine/cosine lane
// angle range reduction, pipelined rotation-mode cordic, quadrant fix-up
// ----------------------------------------------------------------------------
module erm_cordic import erm_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output sincos_t            result
);

    // number of 2*pi binary multiples needed to bring the largest input below 2*pi
    function automatic int wrap_steps();
        longint lim;
        int     k;
        lim = longint'(1) <<< (WFRAC - ANGLE_FRAC_BITS + 15);
        k = 0;
        while ((longint'(TWO_PI_W) <<< k) <= lim) k++;
        return k;
    endfunction

    localparam int N     = CORDIC_STAGES;
    localparam int RW    = (WFRAC - ANGLE_FRAC_BITS + 17 > WW) ?
                           (WFRAC - ANGLE_FRAC_BITS + 17) : WW;
    localparam int NWRAP = wrap_steps();

    typedef logic signed [RW-1:0] wide_t;

    // range reduction: truncating remainder by 2*pi on the magnitude,
    // subtracting 2*pi * 2^k from the largest k down
    wide_t z_in, z_mag;
    word_t z_r1, z_r2;
    logic  neg_in;
    always_comb begin
        z_in = wide_t'(angle) <<< (WFRAC - ANGLE_FRAC_BITS);
        z_mag = z_in[RW-1] ? -z_in : z_in;
        for (int k = NWRAP - 1; k >= 0; k--) begin
            if (z_mag >= (wide_t'(TWO_PI_W) <<< k)) z_mag = z_mag - (wide_t'(TWO_PI_W) <<< k);
        end
        z_r1 = word_t'(z_in[RW-1] ? -z_mag : z_mag);
        if (z_r1 > PI_W) z_r1 = z_r1 - TWO_PI_W;
        if (z_r1 < -PI_W) z_r1 = z_r1 + TWO_PI_W;
        neg_in = 1'b0;
        z_r2 = z_r1;
        if (z_r1 > HALF_PI_W) begin
            z_r2 = z_r1 - PI_W;
            neg_in = 1'b1;
        end else if (z_r1 < -HALF_PI_W) begin
            z_r2 = z_r1 + PI_W;
            neg_in = 1'b1;
        end
    end

    word_t x_reg [N+1];
    word_t y_reg [N+1];
    word_t z_reg [N+1];
    logic  neg_reg [N+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= GAIN_INV_W;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_r2;
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        word_t xs, ys, at;
        assign xs = (i < WW) ? (x_reg[i] >>> i) : (x_reg[i] >>> (WW - 1));
        assign ys = (i < WW) ? (y_reg[i] >>> i) : (y_reg[i] >>> (WW - 1));
        assign at = atan_step(i);
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][WW-1]) begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - at;
                end else begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + at;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result.s <= sat_w(neg_reg[N] ? -y_reg[N] : y_reg[N]);
            result.c <= sat_w(neg_reg[N] ? -x_reg[N] : x_reg[N]);
        end
    end

endmodule

// ===== rtl/core/erm_compose.sv =====
// ----------------------------------------------------------------------------
// erm_compose: merges the three lanes into the nine matrix entries
// two product stages, the second also forming the sums, then rounding and saturation
// ----------------------------------------------------------------------------
module erm_compose import erm_pkg::*; #(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               en,
    input  sincos_t            lx,
    input  sincos_t            ly,
    input  sincos_t            lz,
    output logic signed [15:0] r_out [9]
);

    localparam int SH = WFRAC - COEF_FRAC_BITS;

    // stage 1: two-factor products
    word_t sxsy_reg, sycx_reg, sysz_reg, cycz_reg, szcy_reg, szcx_reg, cxcz_reg;
    word_t sxcy_reg, sxsz_reg, sxcz_reg, cxcy_reg;
    word_t sy1_reg, sz1_reg, cz1_reg, cx1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sxsy_reg <= mulw(lx.s, ly.s);
            sycx_reg <= mulw(ly.s, lx.c);
            sysz_reg <= mulw(ly.s, lz.s);
            cycz_reg <= mulw(ly.c, lz.c);
            szcy_reg <= mulw(lz.s, ly.c);
            szcx_reg <= mulw(lz.s, lx.c);
            cxcz_reg <= mulw(lx.c, lz.c);
            sxcy_reg <= mulw(lx.s, ly.c);
            sxsz_reg <= mulw(lx.s, lz.s);
            sxcz_reg <= mulw(lx.s, lz.c);
            cxcy_reg <= mulw(lx.c, ly.c);
            sy1_reg  <= ly.s;
            sz1_reg  <= lz.s;
            cz1_reg  <= lz.c;
            cx1_reg  <= lx.c;
        end
    end

    // stage 2: three-factor products and sums
    word_t e_reg [9];
    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg[0] <= cycz_reg;
            e_reg[1] <= -szcy_reg;
            e_reg[2] <= sy1_reg;
            e_reg[3] <= mulw(sxsy_reg, cz1_reg) + szcx_reg;
            e_reg[4] <= -mulw(sxsy_reg, sz1_reg) + cxcz_reg;
            e_reg[5] <= -sxcy_reg;
            e_reg[6] <= sxsz_reg - mulw(sycx_reg, cz1_reg);
            e_reg[7] <= sxcz_reg + mulw(sysz_reg, cx1_reg);
            e_reg[8] <= cxcy_reg;
        end
    end

    // stage 3: round half up and saturate
    for (genvar j = 0; j < 9; j++) begin : g_out
        word_t rv;
        always_comb begin
            if (SH > 0) rv = (e_reg[j] + (word_t'(1) <<< (SH - 1))) >>> SH;
            else rv = e_reg[j] <<< (-SH);
            if (rv > (word_t'(1) <<< COEF_FRAC_BITS)) rv = word_t'(1) <<< COEF_FRAC_BITS;
            if (rv < -(word_t'(1) <<< COEF_FRAC_BITS)) rv = -(word_t'(1) <<< COEF_FRAC_BITS);
            if (rv > 34'sd32767) rv = 34'sd32767;
            if (rv < -34'sd32768) rv = -34'sd32768;
        end
        always_ff @(posedge aclk) begin
            if (en) r_out[j] <= rv[15:0];
        end
    end

endmodule

// ===== rtl/core/euler_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_rotation_matrix: 3x3 rotation matrix from x, y, z euler angles
// ----------------------------------------------------------------------------
// Fully pipelined: one request is accepted every cycle while the output is not
// stalled, and each passes through one register per cordic iteration, plus
// input, sine/cosine, two product and one rounding stage.
// Three cordic lanes run side by side, one per angle, and a merging stage forms
// the nine entries. The whole pipe advances only while the output register can
// take data, so a stall at m_ready holds every stage in place.
module euler_rotation_matrix import erm_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
    parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS,
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_angle_x,
    input  logic signed [15:0] s_angle_y,
    input  logic signed [15:0] s_angle_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_r00,
    output logic signed [15:0] m_r01,
    output logic signed [15:0] m_r02,
    output logic signed [15:0] m_r10,
    output logic signed [15:0] m_r11,
    output logic signed [15:0] m_r12,
    output logic signed [15:0] m_r20,
    output logic signed [15:0] m_r21,
    output logic signed [15:0] m_r22
);

    localparam int DEPTH = CORDIC_STAGES + 5;

    logic [DEPTH-1:0] vld_reg;
    logic             en;
    sincos_t          lx, ly, lz;
    logic signed [15:0] r [9];

    assign en      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
    end

    erm_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_x (
        .aclk(aclk), .en(en), .angle(s_angle_x), .result(lx));
    erm_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_y (
        .aclk(aclk), .en(en), .angle(s_angle_y), .result(ly));
    erm_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_z (
        .aclk(aclk), .en(en), .angle(s_angle_z), .result(lz));

    erm_compose #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_compose (
        .aclk(aclk), .en(en), .lx(lx), .ly(ly), .lz(lz), .r_out(r));

    assign m_r00 = r[0];
    assign m_r01 = r[1];
    assign m_r02 = r[2];
    assign m_r10 = r[3];
    assign m_r11 = r[4];
    assign m_r12 = r[5];
    assign m_r20 = r[6];
    assign m_r21 = r[7];
    assign m_r22 = r[8];

    // a stalled result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_r00) && $stable(m_r22))
        else $error("result changed while stalled");
    // a request accepted enters the pipe
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request lost");
    // pipe never advances into a stalled output
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during stall");

endmodule
